// ===== src/cts_pkg.sv =====
// shared types and constants of the cosine top-k vector search
package cts_pkg;

  // fixed field widths
  localparam int VL_W = 7;
  localparam int ELEM_W = 16;
  localparam int VID_W = 10;
  localparam int SIM_W = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register map
  localparam logic [PADDR_W-1:0] ADDR_VECTOR_LENGTH = 3'd0;
  localparam logic [VL_W-1:0] VL_RESET = 7'd64;

  // similarity codes
  localparam logic signed [SIM_W-1:0] SIM_ZERO_NORM = -16'sd32768;
  localparam logic signed [SIM_W-1:0] SIM_MAX = 16'sd32767;

  // command of one element
  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_MATCH  = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_LENGTH = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  // request payload
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [ELEM_W-1:0] element;
    logic                     last;
  } item_t;

  // result payload
  typedef struct packed {
    status_t                 status;
    logic [VID_W-1:0]        vector_id;
    logic signed [SIM_W-1:0] similarity;
    logic                    last_result;
  } result_t;

endpackage

// ===== src/cts_ram.sv =====
// generic single-port-write ram with registered read
module cts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cts_sim.sv =====
// cosine similarity unit: serial multiplies, restoring divide, digit square root
module cts_sim
  import cts_pkg::*;
#(
  parameter int NORM_W = 38
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NORM_W-1:0]        mag,
  input  logic                     neg,
  input  logic [NORM_W-1:0]        qnorm,
  input  logic [NORM_W-1:0]        snorm,
  output logic                     done,
  output logic signed [SIM_W-1:0]  sim
);

  localparam int PROD_W = 2 * NORM_W;
  localparam int REM_W = PROD_W + 33;
  localparam int CNT_W = $clog2(NORM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DCHK,
    S_DIV,
    S_SQRT,
    S_FIN
  } state_t;

  state_t              state;
  logic [PROD_W-1:0]   mcand;
  logic [NORM_W-1:0]   mplier;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rsq;
  logic [NORM_W-1:0]   qn;
  logic [NORM_W-1:0]   sn;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    dvs;
  logic [31:0]         quo;
  logic [15:0]         root;
  logic [CNT_W-1:0]    cnt;
  logic                neg_r;

  logic [PROD_W-1:0]   prod_next;
  logic [15:0]         trial;
  logic [31:0]         trial_sq;
  logic [16:0]         lo;
  logic [16:0]         lo_neg;

  // shift-add step, square root trial and final clamp
  always_comb begin
    prod_next = prod + (mplier[0] ? mcand : '0);
    trial = root | (16'(1) << (cnt - CNT_W'(1)));
    trial_sq = trial * trial;
    lo = (root > 16'd32768) ? 17'd32768 : {1'b0, root};
    lo_neg = -lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg_r <= neg;
            qn <= qnorm;
            sn <= snorm;
            if (qnorm == '0 || snorm == '0) begin
              sim <= SIM_ZERO_NORM;
              done <= 1'b1;
            end else begin
              mcand <= PROD_W'(mag);
              mplier <= mag;
              prod <= '0;
              cnt <= CNT_W'(NORM_W);
              state <= S_MUL1;
            end
          end
        end
        // dot magnitude squared
        S_MUL1: begin
          prod <= prod_next;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            rsq <= prod_next;
            mcand <= PROD_W'(qn);
            mplier <= sn;
            prod <= '0;
            cnt <= CNT_W'(NORM_W);
            state <= S_MUL2;
          end
        end
        // product of the two norms
        S_MUL2: begin
          prod <= prod_next;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            rem <= REM_W'(rsq) << 30;
            dvs <= REM_W'(prod_next) << 31;
            state <= S_DCHK;
          end
        end
        // quotient beyond 32 bits saturates
        S_DCHK: begin
          quo <= '0;
          if (rem >= (dvs << 1)) begin
            quo <= '1;
            root <= '0;
            cnt <= CNT_W'(16);
            state <= S_SQRT;
          end else begin
            cnt <= CNT_W'(32);
            state <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (rem >= dvs) begin
            rem <= rem - dvs;
            quo <= {quo[30:0], 1'b1};
          end else begin
            quo <= {quo[30:0], 1'b0};
          end
          dvs <= dvs >> 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            root <= '0;
            cnt <= CNT_W'(16);
            state <= S_SQRT;
          end
        end
        // one root bit per cycle
        S_SQRT: begin
          if (trial_sq <= quo) begin
            root <= trial;
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (neg_r) begin
            sim <= lo_neg[SIM_W-1:0];
          end else if (lo > 17'd32767) begin
            sim <= SIM_MAX;
          end else begin
            sim <= lo[SIM_W-1:0];
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/cts_topk.sv =====
// sorted best-k list with shift-register insertion
module cts_topk
  import cts_pkg::*;
#(
  parameter int TOP_K = 5,
  parameter int ID_W = 10
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        clear,
  input  logic                                        ins,
  input  logic [ID_W-1:0]                             ins_id,
  input  logic signed [SIM_W-1:0]                     ins_score,
  input  logic [((TOP_K > 1) ? $clog2(TOP_K) : 1)-1:0] rd_idx,
  output logic [$clog2(TOP_K + 1)-1:0]                filled,
  output logic [ID_W-1:0]                             rd_id,
  output logic signed [SIM_W-1:0]                     rd_score
);

  localparam int KC_W = $clog2(TOP_K + 1);

  logic [ID_W-1:0]         ids [TOP_K];
  logic signed [SIM_W-1:0] scores [TOP_K];
  logic [TOP_K-1:0]        keep;
  logic [TOP_K-1:0]        at_pos;

  // entries at least as good as the new score stay in front
  always_comb begin
    for (int j = 0; j < TOP_K; j++) begin
      keep[j] = (KC_W'(j) < filled) && (scores[j] >= ins_score);
    end
    for (int j = 0; j < TOP_K; j++) begin
      if (j == 0) begin
        at_pos[j] = !keep[j];
      end else begin
        at_pos[j] = !keep[j] && keep[j-1];
      end
    end
  end

  // shift the tail down and place the new entry
  always_ff @(posedge clk) begin
    if (ins) begin
      for (int j = 0; j < TOP_K; j++) begin
        if (at_pos[j]) begin
          ids[j] <= ins_id;
          scores[j] <= ins_score;
        end else if (!keep[j] && j > 0) begin
          ids[j] <= ids[j-1];
          scores[j] <= scores[j-1];
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      filled <= '0;
    end else if (ins && filled < KC_W'(TOP_K)) begin
      filled <= filled + KC_W'(1);
    end
  end

  assign rd_id = ids[rd_idx];
  assign rd_score = scores[rd_idx];

endmodule

// ===== src/cosine_top_k_vector_search.sv =====
// top level: element intake, memory sweeps, search sequencer and result register
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  request   | item_valid, item_ready, item (item_t)     | in
//  result    | result_valid, result_ready, result        | out
//  config    | psel penable pwrite paddr pwdata prdata   | apb
//
// a write with last sweeps its slot for the norm. a query sweeps the query
// buffer, then for each stored vector runs a dot product sweep and the
// similarity unit, then emits one result per cycle while the result register is free.
// reset clears counters and control; memories are not cleared. requests are
// taken only while the sequencer is idle; a full result register stalls it.
module cosine_top_k_vector_search
  import cts_pkg::*;
#(
  parameter int MAX_VECTORS = 1024,
  parameter int MAX_DIM = 64,
  parameter int TOP_K = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int ID_W = $clog2(MAX_VECTORS);
  localparam int SC_W = $clog2(MAX_VECTORS + 1);
  localparam int EC_W = $clog2(MAX_DIM + 1);
  localparam int QA_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int VDEPTH = MAX_VECTORS * MAX_DIM;
  localparam int VA_W = $clog2(VDEPTH);
  localparam int NORM_W = 32 + $clog2(MAX_DIM);
  localparam int ACC_W = NORM_W + 1;
  localparam int KC_W = $clog2(TOP_K + 1);
  localparam int KI_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_WAIT,
    S_RESP,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    M_NORM_W,
    M_NORM_Q,
    M_DOT
  } mode_t;

  state_t                  state;
  mode_t                   mode;
  logic [VL_W-1:0]         vl;
  logic [EC_W-1:0]         elem_cnt;
  logic                    len_err;
  logic [SC_W-1:0]         stored;
  logic [VA_W-1:0]         wbase;
  logic [VA_W-1:0]         qbase;
  logic [SC_W-1:0]         slot;
  logic [EC_W-1:0]         sweep_len;
  logic [EC_W-1:0]         iss;
  logic                    p1;
  logic                    p2;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic [NORM_W-1:0]       qnorm;
  logic [KC_W-1:0]         eidx;
  result_t                 resp;

  // element intake
  logic                    accept;
  logic                    over;
  logic [EC_W-1:0]         cnt_after;
  logic                    err_after;
  logic                    len_ok;
  logic [EC_W-1:0]         dot_len;

  // sweep control
  logic                    issuing;
  logic                    sweep_done;
  logic signed [ELEM_W-1:0] mul_a;
  logic signed [ELEM_W-1:0] mul_b;
  logic signed [ACC_W-1:0] acc_neg;

  // memory ports
  logic                    vmem_we;
  logic [VA_W-1:0]         vmem_waddr;
  logic                    vmem_re;
  logic [VA_W-1:0]         vmem_raddr;
  logic [ELEM_W-1:0]       vmem_rdata;
  logic                    qbuf_we;
  logic                    qbuf_re;
  logic [ELEM_W-1:0]       qbuf_rdata;
  logic                    nmem_we;
  logic                    nmem_re;
  logic [ID_W-1:0]         nmem_raddr;
  logic [NORM_W-1:0]       nmem_rdata;

  // similarity and list
  logic                    sim_start;
  logic                    sim_done;
  logic signed [SIM_W-1:0] sim_val;
  logic [NORM_W-1:0]       mag;
  logic                    topk_clear;
  logic [KC_W-1:0]         filled;
  logic [ID_W-1:0]         rd_id;
  logic signed [SIM_W-1:0] rd_score;
  logic                    out_free;
  logic                    slot_last;

  // element bookkeeping
  always_comb begin
    accept = item_valid && item_ready;
    over = (32'(elem_cnt) >= 32'(vl)) || (32'(elem_cnt) >= MAX_DIM);
    cnt_after = over ? elem_cnt : elem_cnt + EC_W'(1);
    err_after = len_err || over;
    len_ok = !err_after && (32'(cnt_after) == 32'(vl));
    dot_len = (32'(vl) < MAX_DIM) ? EC_W'(vl) : EC_W'(MAX_DIM);
  end

  // memory port control
  always_comb begin
    issuing = (state == S_SWEEP) && (iss != sweep_len);
    sweep_done = (state == S_SWEEP) && (iss == sweep_len) && !p1 && !p2;
    qbuf_we = accept && !over && (item.cmd == CMD_QUERY);
    vmem_we = accept && !over && (item.cmd == CMD_STORE) && (32'(stored) < MAX_VECTORS);
    vmem_waddr = wbase + VA_W'(elem_cnt);
    vmem_re = issuing && (mode != M_NORM_Q);
    vmem_raddr = ((mode == M_DOT) ? qbase : wbase) + VA_W'(iss);
    qbuf_re = issuing && (mode != M_NORM_W);
    nmem_we = sweep_done && (mode == M_NORM_W);
    slot_last = (slot + SC_W'(1)) == stored;
    nmem_re = 1'b0;
    nmem_raddr = '0;
    if (sweep_done && mode == M_NORM_Q) begin
      nmem_re = 1'b1;
    end else if (state == S_WAIT && sim_done && !slot_last) begin
      nmem_re = 1'b1;
      nmem_raddr = ID_W'(slot + SC_W'(1));
    end
    mul_a = (mode == M_NORM_Q) ? $signed(qbuf_rdata) : $signed(vmem_rdata);
    mul_b = (mode == M_DOT) ? $signed(qbuf_rdata) : mul_a;
    acc_neg = -acc;
    mag = acc[ACC_W-1] ? NORM_W'(acc_neg) : NORM_W'(acc);
    sim_start = sweep_done && (mode == M_DOT);
    topk_clear = sweep_done && (mode == M_NORM_Q);
    out_free = !result_valid || result_ready;
  end

  cts_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (VDEPTH)
  ) u_vmem (
    .clk   (clk),
    .we    (vmem_we),
    .waddr (vmem_waddr),
    .wdata (item.element),
    .re    (vmem_re),
    .raddr (vmem_raddr),
    .rdata (vmem_rdata)
  );

  cts_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_qbuf (
    .clk   (clk),
    .we    (qbuf_we),
    .waddr (elem_cnt[QA_W-1:0]),
    .wdata (item.element),
    .re    (qbuf_re),
    .raddr (iss[QA_W-1:0]),
    .rdata (qbuf_rdata)
  );

  cts_ram #(
    .WIDTH (NORM_W),
    .DEPTH (MAX_VECTORS)
  ) u_nmem (
    .clk   (clk),
    .we    (nmem_we),
    .waddr (stored[ID_W-1:0]),
    .wdata (NORM_W'(acc)),
    .re    (nmem_re),
    .raddr (nmem_raddr),
    .rdata (nmem_rdata)
  );

  cts_sim #(
    .NORM_W (NORM_W)
  ) u_sim (
    .clk   (clk),
    .rst   (rst),
    .start (sim_start),
    .mag   (mag),
    .neg   (acc[ACC_W-1]),
    .qnorm (qnorm),
    .snorm (nmem_rdata),
    .done  (sim_done),
    .sim   (sim_val)
  );

  cts_topk #(
    .TOP_K (TOP_K),
    .ID_W  (ID_W)
  ) u_topk (
    .clk       (clk),
    .rst       (rst),
    .clear     (topk_clear),
    .ins       (state == S_WAIT && sim_done),
    .ins_id    (slot[ID_W-1:0]),
    .ins_score (sim_val),
    .rd_idx    (eidx[KI_W-1:0]),
    .filled    (filled),
    .rd_id     (rd_id),
    .rd_score  (rd_score)
  );

  assign item_ready = (state == S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == ADDR_VECTOR_LENGTH[PADDR_W-1:2])
                  ? PDATA_W'(vl) : '0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= VL_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1:2] == ADDR_VECTOR_LENGTH[PADDR_W-1:2]) begin
      vl <= pwdata[VL_W-1:0];
    end
  end

  // sweep datapath: product stage then accumulate
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (p2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (issuing) begin
      iss <= iss + EC_W'(1);
    end
    if (state == S_IDLE || (sweep_done && mode == M_NORM_Q)
        || (state == S_WAIT && sim_done)) begin
      acc <= '0;
      iss <= '0;
    end
    if (sweep_done && mode == M_NORM_Q) begin
      qnorm <= NORM_W'(acc);
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= M_NORM_W;
      elem_cnt <= '0;
      len_err <= 1'b0;
      stored <= '0;
      wbase <= '0;
      p1 <= 1'b0;
      p2 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p1 <= issuing;
      p2 <= p1;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            elem_cnt <= cnt_after;
            len_err <= err_after;
            if (item.last) begin
              elem_cnt <= '0;
              len_err <= 1'b0;
              resp.vector_id <= '0;
              resp.similarity <= '0;
              resp.last_result <= 1'b1;
              if (!len_ok) begin
                resp.status <= ST_LENGTH;
                state <= S_RESP;
              end else if (item.cmd == CMD_STORE) begin
                if (32'(stored) >= MAX_VECTORS) begin
                  resp.status <= ST_FULL;
                  state <= S_RESP;
                end else begin
                  mode <= M_NORM_W;
                  sweep_len <= EC_W'(vl);
                  state <= S_SWEEP;
                end
              end else if (stored == '0) begin
                resp.status <= ST_EMPTY;
                state <= S_RESP;
              end else begin
                mode <= M_NORM_Q;
                sweep_len <= EC_W'(vl);
                state <= S_SWEEP;
              end
            end
          end
        end
        S_SWEEP: begin
          if (sweep_done) begin
            unique case (mode)
              M_NORM_W: begin
                resp.status <= ST_STORED;
                resp.vector_id <= VID_W'(stored[ID_W-1:0]);
                stored <= stored + SC_W'(1);
                wbase <= wbase + VA_W'(MAX_DIM);
                state <= S_RESP;
              end
              M_NORM_Q: begin
                slot <= '0;
                qbase <= '0;
                mode <= M_DOT;
                sweep_len <= dot_len;
              end
              M_DOT: begin
                state <= S_WAIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (sim_done) begin
            if (slot_last) begin
              eidx <= '0;
              state <= S_EMIT;
            end else begin
              slot <= slot + SC_W'(1);
              qbase <= qbase + VA_W'(MAX_DIM);
              state <= S_SWEEP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            result <= resp;
            result_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.status <= ST_MATCH;
            result.vector_id <= VID_W'(rd_id);
            result.similarity <= rd_score;
            result.last_result <= (eidx + KC_W'(1)) == filled;
            result_valid <= 1'b1;
            eidx <= eidx + KC_W'(1);
            if ((eidx + KC_W'(1)) == filled) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
